>>> sv/slx_pkg.sv
// Shared types, token kinds and keyword tables for the source lexer.
// No dependencies.
`timescale 1ns / 1ps
package slx_pkg;

    localparam int POS_BITS  = 16;
    localparam int LINE_BITS = 16;
    localparam int KW_COUNT  = 16;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = 2;

    localparam logic [5:0] K_IDENT  = 6'd0;
    localparam logic [5:0] K_NUMBER = 6'd1;
    localparam logic [5:0] K_STRING = 6'd2;
    localparam logic [5:0] K_ERROR  = 6'd3;
    localparam logic [5:0] K_KW0    = 6'd4;
    localparam logic [5:0] K_SLASH  = 6'd29;
    localparam logic [5:0] K_BANG   = 6'd31;
    localparam logic [5:0] K_EQ     = 6'd33;
    localparam logic [5:0] K_LT     = 6'd35;
    localparam logic [5:0] K_GT     = 6'd37;

    // One token as it travels from the scanner to the output stage.
    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] line_no;
        logic [15:0] start_pos;
        logic [15:0] length;
        logic        last;
    } token_t;

    // Up to two tokens produced by one character.
    typedef struct packed {
        logic   [1:0] count;
        token_t       tok0;
        token_t       tok1;
    } tok_pair_t;

    function automatic int kw_len(input logic [3:0] k);
        case (k)
            4'd0: return 3;  4'd1: return 5;  4'd2: return 4;  4'd3: return 5;
            4'd4: return 3;  4'd5: return 3;  4'd6: return 2;  4'd7: return 3;
            4'd8: return 2;  4'd9: return 5;  4'd10: return 6; 4'd11: return 5;
            4'd12: return 4; 4'd13: return 4; 4'd14: return 3; default: return 5;
        endcase
    endfunction

    function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] i);
        logic [55:0] s;
        case (k)
            4'd0:  s = "and";
            4'd1:  s = "class";
            4'd2:  s = "else";
            4'd3:  s = "false";
            4'd4:  s = "for";
            4'd5:  s = "fun";
            4'd6:  s = "if";
            4'd7:  s = "nil";
            4'd8:  s = "or";
            4'd9:  s = "print";
            4'd10: s = "return";
            4'd11: s = "super";
            4'd12: s = "this";
            4'd13: s = "true";
            4'd14: s = "var";
            default: s = "while";
        endcase
        // String literals are right aligned; find character i from the left.
        return s[8*(kw_len(k) - 1 - i) +: 8];
    endfunction

    function automatic logic [15:0] sat16(input logic [31:0] v);
        return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

endpackage

>>> sv/source_lexer.sv
// Top level of the streaming source lexer: scanner front, token queue, output.
// Depends on slx_pkg, slx_scan and slx_queue.
// Tokens are written into the token queue registers and presented to the output
// from there. Throughput: one character per cycle while the queue has room for two
// tokens; a character that makes two tokens is absorbed at once, and the four-entry
// token queue drains one token per cycle while m_tready is high. Reset (rst_n low,
// asynchronous) empties the queue and returns the scanner to line 0, offset 0.
`timescale 1ns / 1ps
module source_lexer
    import slx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch
    input  logic        s_tlast,   // end_of_source
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // kind[5:0], line_no, start_pos, length, zero fill
    output logic        m_tlast    // last_of_run
);

    tok_pair_t toks;
    token_t    head;
    logic      step;
    logic      room2;

    // A character is taken whenever the queue can hold the two tokens it
    // might make, so the scanner never waits on the consumer while space lasts.
    assign s_tready = room2;
    assign step     = s_tvalid && s_tready;

    slx_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .ch    (s_tdata),
        .eos   (s_tlast),
        .toks  (toks)
    );

    slx_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .wr        (toks),
        .room2     (room2),
        .out_valid (m_tvalid),
        .out_tok   (head),
        .pop       (m_tready)
    );

    assign m_tdata = {2'b00, head.length, head.start_pos, head.line_no, head.kind};
    assign m_tlast = head.last;

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[5:0] <= 6'd42)
        else $error("token kind out of range");

    a_no_take_full: assert property (@(posedge clk) disable iff (!rst_n)
        !room2 |-> !step)
        else $error("character taken without queue room");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("queued token changed while stalled");

endmodule

>>> sv/slx_scan.sv
// Front part of the lexer: per-character scanner state and token forming.
// Depends on slx_pkg.
`timescale 1ns / 1ps
module slx_scan
    import slx_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic [7:0]      ch,
    input  logic            eos,
    output tok_pair_t       toks
);

    typedef enum logic [2:0] {
        M_IDLE, M_IDENT, M_INT, M_FRAC, M_STR, M_COMMENT, M_OPWAIT
    } mode_t;

    mode_t                 mode_reg, mode_next;
    logic [7:0]            pend_reg, pend_next;
    logic [POS_BITS-1:0]   start_reg, start_next;
    logic [15:0]           len_reg, len_next;
    logic [LINE_BITS-1:0]  line_reg, line_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic [KW_COUNT-1:0]   mask_reg, mask_next;
    logic                  bs_reg, bs_next;

    logic [1:0]            n;
    token_t                t0, t1;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        case (c)
            "(": return 6'd20; ")": return 6'd21; "{": return 6'd22;
            "}": return 6'd23; ",": return 6'd24; ".": return 6'd25;
            "-": return 6'd26; "+": return 6'd27; ";": return 6'd28;
            "*": return 6'd30; "~": return 6'd39; "?": return 6'd40;
            ":": return 6'd41; "^": return 6'd42;
            default: return K_IDENT;
        endcase
    endfunction

    function automatic logic [5:0] wait_kind(input logic [7:0] c, input logic eq);
        logic [5:0] b;
        case (c)
            "!": b = K_BANG;
            "=": b = K_EQ;
            "<": b = K_LT;
            ">": b = K_GT;
            default: return K_SLASH;
        endcase
        return eq ? b + 6'd1 : b;
    endfunction

    // Keyword mask after adding character c at identifier position idx.
    function automatic logic [KW_COUNT-1:0] mask_add(input logic [KW_COUNT-1:0] m,
        input logic [15:0] idx, input logic [7:0] c);
        logic [KW_COUNT-1:0] r;
        r = m;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (idx >= 16'(kw_len(4'(k))) || kw_char(4'(k), idx[2:0]) != c)
                r[k] = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [5:0] ident_kind(input logic [KW_COUNT-1:0] m,
        input logic [15:0] l);
        logic [5:0] r;
        r = K_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (m[k] && l == 16'(kw_len(4'(k))))
                r = K_KW0 + 6'(k);
        end
        return r;
    endfunction

    always_comb
    begin
        logic                 do_begin;
        logic [LINE_BITS-1:0] ln;
        logic [5:0]           ek;
        logic [15:0]          el;
        logic                 emit_a;
        logic [5:0]           k;

        mode_next  = mode_reg;
        pend_next  = pend_reg;
        start_next = start_reg;
        len_next   = len_reg;
        line_next  = line_reg;
        mask_next  = mask_reg;
        bs_next    = bs_reg;
        pos_next   = (pos_reg != {POS_BITS{1'b1}}) ? pos_reg + 1'b1 : pos_reg;
        do_begin   = 1'b0;
        emit_a     = 1'b0;
        ek         = K_IDENT;
        el         = 16'd0;
        k          = K_IDENT;
        n          = 2'd0;
        t0         = '0;
        t1         = '0;
        ln         = line_reg;

        case (mode_reg)
            M_IDENT:
            begin
                if (is_alpha(ch) || is_digit(ch))
                begin
                    mask_next = mask_add(mask_reg, len_reg, ch);
                    len_next  = (len_reg != 16'hFFFF) ? len_reg + 1'b1 : len_reg;
                end
                else
                begin
                    emit_a = 1'b1; ek = ident_kind(mask_reg, len_reg); el = len_reg;
                    do_begin = 1'b1;
                end
            end
            M_INT, M_FRAC:
            begin
                if (is_digit(ch) || (mode_reg == M_INT && ch == "."))
                begin
                    len_next = (len_reg != 16'hFFFF) ? len_reg + 1'b1 : len_reg;
                    if (ch == ".")
                        mode_next = M_FRAC;
                end
                else
                begin
                    emit_a = 1'b1; ek = K_NUMBER; el = len_reg; do_begin = 1'b1;
                end
            end
            M_STR:
            begin
                if (ch == 8'h0A)
                begin
                    emit_a = 1'b1; ek = K_ERROR; el = len_reg;
                    if (line_reg != {LINE_BITS{1'b1}})
                        line_next = line_reg + 1'b1;
                    mode_next = M_IDLE;
                end
                else if (ch == "\"" && !bs_reg)
                begin
                    emit_a = 1'b1; ek = K_STRING; el = len_reg; mode_next = M_IDLE;
                end
                else
                begin
                    len_next = (len_reg != 16'hFFFF) ? len_reg + 1'b1 : len_reg;
                    bs_next  = (ch == 8'h5C);
                end
            end
            M_COMMENT:
            begin
                if (ch == 8'h0A)
                begin
                    if (line_reg != {LINE_BITS{1'b1}})
                        line_next = line_reg + 1'b1;
                    mode_next = M_IDLE;
                end
            end
            M_OPWAIT:
            begin
                if (pend_reg == "/")
                begin
                    if (ch == "/")
                        mode_next = M_COMMENT;
                    else
                    begin
                        emit_a = 1'b1; ek = K_SLASH; el = 16'd1; do_begin = 1'b1;
                    end
                end
                else if (ch == "=")
                begin
                    emit_a = 1'b1; ek = wait_kind(pend_reg, 1'b1); el = 16'd2;
                    mode_next = M_IDLE;
                end
                else
                begin
                    emit_a = 1'b1; ek = wait_kind(pend_reg, 1'b0); el = 16'd1;
                    do_begin = 1'b1;
                end
            end
            default: do_begin = 1'b1;
        endcase

        if (emit_a)
        begin
            t0.kind      = ek;
            t0.line_no   = sat16(32'(ln));
            t0.start_pos = sat16(32'(start_reg));
            t0.length    = el;
            n            = 2'd1;
        end

        if (do_begin)
        begin
            mode_next = M_IDLE;
            k = single_kind(ch);
            if (is_digit(ch))
            begin
                mode_next = M_INT; start_next = pos_reg; len_next = 16'd1;
            end
            else if (is_alpha(ch))
            begin
                mode_next  = M_IDENT; start_next = pos_reg; len_next = 16'd1;
                mask_next  = mask_add({KW_COUNT{1'b1}}, 16'd0, ch);
            end
            else if (ch == 8'h0A)
            begin
                if (line_reg != {LINE_BITS{1'b1}})
                    line_next = line_reg + 1'b1;
            end
            else if (ch == "\"")
            begin
                mode_next = M_STR; start_next = pos_reg; len_next = 16'd0; bs_next = 1'b0;
            end
            else if (ch == "!" || ch == "=" || ch == "<" || ch == ">" || ch == "/")
            begin
                mode_next = M_OPWAIT; pend_next = ch; start_next = pos_reg;
            end
            else if (k != K_IDENT)
            begin
                if (n == 2'd0)
                begin
                    t0 = '{k, sat16(32'(line_reg)), sat16(32'(pos_reg)), 16'd1, 1'b0};
                    n  = 2'd1;
                end
                else
                begin
                    t1 = '{k, sat16(32'(line_reg)), sat16(32'(pos_reg)), 16'd1, 1'b0};
                    n  = 2'd2;
                end
            end
        end

        if (eos)
        begin
            emit_a = 1'b1;
            case (mode_next)
                M_IDENT:  begin ek = ident_kind(mask_next, len_next); el = len_next; end
                M_INT,
                M_FRAC:   begin ek = K_NUMBER; el = len_next; end
                M_STR:    begin ek = K_ERROR; el = len_next; end
                M_OPWAIT: begin ek = wait_kind(pend_next, 1'b0); el = 16'd1; end
                default:  emit_a = 1'b0;
            endcase
            if (emit_a && n != 2'd2)
            begin
                if (n == 2'd0)
                begin
                    t0 = '{ek, sat16(32'(line_next)), sat16(32'(start_next)), el, 1'b0};
                    n  = 2'd1;
                end
                else
                begin
                    t1 = '{ek, sat16(32'(line_next)), sat16(32'(start_next)), el, 1'b0};
                    n  = 2'd2;
                end
            end
            mode_next  = M_IDLE;
            pend_next  = 8'd0;
            start_next = '0;
            len_next   = 16'd0;
            line_next  = '0;
            pos_next   = '0;
            mask_next  = {KW_COUNT{1'b1}};
            bs_next    = 1'b0;
        end

        if (n == 2'd1)
            t0.last = 1'b1;
        else if (n == 2'd2)
            t1.last = 1'b1;
    end

    assign toks = '{n, t0, t1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            pend_reg  <= 8'd0;
            start_reg <= '0;
            len_reg   <= 16'd0;
            line_reg  <= '0;
            pos_reg   <= '0;
            mask_reg  <= {KW_COUNT{1'b1}};
            bs_reg    <= 1'b0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            line_reg  <= line_next;
            pos_reg   <= pos_next;
            mask_reg  <= mask_next;
            bs_reg    <= bs_next;
        end
    end

endmodule

>>> sv/slx_queue.sv
// Token queue between scanner and output: takes up to two tokens per cycle,
// gives one per cycle while pop is high. Depends on slx_pkg.
`timescale 1ns / 1ps
module slx_queue
    import slx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  tok_pair_t wr,
    output logic      room2,
    output logic      out_valid,
    output token_t    out_tok,
    input  logic      pop
);

    token_t          q_reg [Q_DEPTH];
    logic [Q_AW-1:0] rd_reg, wr_reg;
    logic [Q_AW:0]   cnt_reg;
    logic [1:0]      n_in;
    logic            do_pop;

    assign n_in      = push ? wr.count : 2'd0;
    assign out_valid = cnt_reg != '0;
    assign out_tok   = q_reg[rd_reg];
    assign do_pop    = pop && out_valid;
    assign room2     = cnt_reg <= (Q_AW+1)'(Q_DEPTH - 2);

    always_ff @(posedge clk)
    begin
        if (n_in != 2'd0)
            q_reg[wr_reg] <= wr.tok0;
        if (n_in == 2'd2)
            q_reg[wr_reg + 1'b1] <= wr.tok1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_reg + Q_AW'(n_in);
            rd_reg  <= rd_reg + Q_AW'(do_pop);
            cnt_reg <= cnt_reg + (Q_AW+1)'(n_in) - (Q_AW+1)'(do_pop);
        end
    end

endmodule
